/* rtl/point_array_list_defines.svh */
// Assertion macros used by the point list top level.
`ifndef POINT_ARRAY_LIST_DEFINES_SVH
`define POINT_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PAL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pal_pkg.sv */
// Types, constants and codes shared by the point list cells and top level.
`default_nettype none
package pal_pkg;

   localparam int CAPACITY   = 64;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = 6;
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int COORD_W    = 32;
   localparam int PT_W       = 2 * COORD_W;
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_FRONT  = 3'd5,
      CMD_BACK   = 3'd6,
      CMD_CLEAR  = 3'd7
   } pal_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } pal_status_type;

   // Operation broadcast to every cell of the row
   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_INSERT = 2'd2,
      OP_ERASE  = 2'd3
   } pal_op_type;

   typedef struct packed {
      pal_op_type        op;
      logic [IDX_W-1:0]  pos;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_idx;
      logic [PT_W-1:0]   point;
   } pal_cell_ctl_type;

endpackage
`default_nettype wire

/* rtl/pal_cell.sv */
// One storage cell of the point row: holds a point, shifts with its neighbors.
`default_nettype none
module pal_cell (
   input  wire logic                           clock,
   input  wire logic [pal_pkg::IDX_W-1:0]      index,
   input  wire pal_pkg::pal_cell_ctl_type      ctl,
   input  wire logic [pal_pkg::PT_W-1:0]       left_data,
   input  wire logic [pal_pkg::PT_W-1:0]       right_data,
   output logic      [pal_pkg::PT_W-1:0]       data,
   output logic      [pal_pkg::PT_W-1:0]       rd_data
);
   import pal_pkg::*;

   logic [PT_W-1:0] data_ff;

   // Load, shift up on insert, shift down on erase, else hold
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_LOAD: begin
            if (index == ctl.pos) data_ff <= ctl.point;
         end
         OP_INSERT: begin
            if (index == ctl.pos) data_ff <= ctl.point;
            else if (index > ctl.pos) data_ff <= left_data;
         end
         OP_ERASE: begin
            if (index >= ctl.pos) data_ff <= right_data;
         end
         default: begin
            data_ff <= data_ff;
         end
      endcase
   end

   assign data = data_ff;

   // Drive the point onto the read bus only when addressed
   assign rd_data = (ctl.rd_en && (index == ctl.rd_idx)) ? data_ff : '0;

endmodule
`default_nettype wire

/* rtl/point_array_list.sv */
// Point list top level: command decode, count, cell row and read result path.
//
// An ordered list of up to 64 points held in a row of cells, one point per
// cell. Push, pop, insert, erase, read at, front, back and clear each take
// one request; a new request is accepted every clock cycle while the result
// side keeps up, since every cell shifts or loads in parallel in the cycle
// the request is accepted. The accepting edge registers the addressed point
// collected in groups of eight cells, and the groups are then merged into the
// result register, which offers the result, once that register frees up. Two
// results may wait in the pipeline before requests are held off.
`default_nettype none
`include "point_array_list_defines.svh"
module point_array_list (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [pal_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [pal_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [pal_pkg::COORD_W-1:0] req_point_x,
   input  wire logic signed [pal_pkg::COORD_W-1:0] req_point_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [pal_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [pal_pkg::COORD_W-1:0]     rsp_read_x,
   output logic signed [pal_pkg::COORD_W-1:0]     rsp_read_y,
   output logic      [pal_pkg::CNT_W-1:0]         rsp_count,
   output logic                                   rsp_is_empty
);
   import pal_pkg::*;

   logic               accept;
   logic               advance;
   pal_cmd_type        cmd;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   pal_status_type     status;
   logic               full, empty, pos_ok;
   logic [IDX_W-1:0]   pos_idx;
   pal_cell_ctl_type   ctl;

   logic [PT_W-1:0]    cell_data [CAPACITY];
   logic [PT_W-1:0]    cell_rd   [CAPACITY];
   logic [PT_W-1:0]    grp_in    [NUM_GROUPS];
   logic [PT_W-1:0]    grp_ff    [NUM_GROUPS];
   logic [PT_W-1:0]    merged;

   logic               a_valid_ff;
   pal_status_type     a_status_ff;
   logic [CNT_W-1:0]   a_count_ff;

   logic               rsp_valid_ff;
   pal_status_type     rsp_status_ff;
   logic [PT_W-1:0]    rsp_point_ff;
   logic [CNT_W-1:0]   rsp_count_ff;

   // Handshake: move the collect stage when the result register frees up
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !a_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign cmd     = pal_cmd_type'(req_cmd);
   assign pos_idx = IDX_W'(req_position);
   assign full    = (cnt_ff == CNT_W'(CAPACITY));
   assign empty   = (cnt_ff == '0);
   assign pos_ok  = (CNT_W'(req_position) < cnt_ff);

   // Decode the request into status, next count and the cell broadcast
   always_comb begin
      status     = ST_OK;
      cnt_in     = cnt_ff;
      ctl.op     = OP_NONE;
      ctl.pos    = pos_idx;
      ctl.rd_en  = 1'b0;
      ctl.rd_idx = pos_idx;
      ctl.point  = {req_point_y, req_point_x};
      case (cmd)
         CMD_PUSH: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctl.op  = OP_LOAD;
               ctl.pos = cnt_ff[IDX_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         CMD_POP: begin
            if (empty) status = ST_EMPTY;
            else cnt_in = cnt_ff - CNT_W'(1);
         end
         CMD_INSERT: begin
            if (!pos_ok) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ctl.op = OP_INSERT;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         CMD_ERASE: begin
            if (!pos_ok) begin
               status = ST_RANGE;
            end else begin
               ctl.op = OP_ERASE;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         CMD_READ: begin
            if (!pos_ok) status = ST_RANGE;
            else ctl.rd_en = 1'b1;
         end
         CMD_FRONT: begin
            ctl.rd_idx = '0;
            if (empty) status = ST_EMPTY;
            else ctl.rd_en = 1'b1;
         end
         CMD_BACK: begin
            ctl.rd_idx = IDX_W'(cnt_ff - CNT_W'(1));
            if (empty) status = ST_EMPTY;
            else ctl.rd_en = 1'b1;
         end
         CMD_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
      // Drop the broadcast when no request is taken
      if (!accept) begin
         ctl.op    = OP_NONE;
         ctl.rd_en = 1'b0;
      end
   end

   // Row of cells, each linked to its neighbors; the end cells see zero past the row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [PT_W-1:0] left_nb, right_nb;
      if (i == 0) begin : g_first
         assign left_nb = '0;
      end else begin : g_mid_l
         assign left_nb = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_nb = '0;
      end else begin : g_mid_r
         assign right_nb = cell_data[i+1];
      end
      pal_cell u_cell (
         .clock      (clock),
         .index      (IDX_W'(i)),
         .ctl        (ctl),
         .left_data  (left_nb),
         .right_data (right_nb),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // Collect the read bus in groups of eight cells
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_rd[g * GROUP_SIZE + k];
            end
         end
      end
   end

   // Merge the registered groups
   always_comb begin
      merged = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         merged = merged | grp_ff[g];
      end
   end

   // Count and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) cnt_ff <= cnt_in;
         if (req_ready) a_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= a_valid_ff;
      end
   end

   // Collect stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         a_status_ff <= status;
         a_count_ff  <= cnt_in;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance && a_valid_ff) begin
         rsp_status_ff <= a_status_ff;
         rsp_point_ff  <= merged;
         rsp_count_ff  <= a_count_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_read_x   = rsp_point_ff[COORD_W-1:0];
   assign rsp_read_y   = rsp_point_ff[PT_W-1:COORD_W];
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = (rsp_count_ff == '0);

   `PAL_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_ff <= CNT_W'(CAPACITY), "count beyond capacity")
   `PAL_ASSERT_NEXT(a_push_cnt, accept && cmd == CMD_PUSH && !full,
      cnt_ff == $past(cnt_ff) + CNT_W'(1), "push did not advance count")
   `PAL_ASSERT_IMP(a_fail_zero, rsp_valid_ff && rsp_status_ff != ST_OK,
      rsp_point_ff == '0, "read data nonzero on failed request")
   `PAL_ASSERT_NEXT(a_rsp_src, !rsp_valid_ff && !a_valid_ff, !rsp_valid_ff,
      "result appeared without a collected request")

endmodule
`default_nettype wire
